FILE: sv/mtaf_pkg.sv
package mtaf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int AVG_W    = 12;

	typedef struct packed {
		logic                gt;
		logic [SAMPLE_W-1:0] val;
		logic [SAMPLE_W-1:0] ins;
	} cell_link_t;

	typedef struct packed {
		logic                req;
		logic [SAMPLE_W-1:0] value;
	} median_t;

	typedef enum logic {
		AVG_IDLE,
		AVG_DIV
	} avg_state_t;

endpackage

FILE: sv/mtaf_cell.sv
module mtaf_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic                          clear,
	input  logic [mtaf_pkg::SAMPLE_W-1:0] sample,
	input  mtaf_pkg::cell_link_t          left,
	output mtaf_pkg::cell_link_t          link
);
	import mtaf_pkg::*;

	logic [SAMPLE_W-1:0] val_q;
	logic [SAMPLE_W-1:0] ins;
	logic                gt;

	// entry moves right when the sample beats it; it takes the left entry
	// if that one moved too, else the sample itself
	assign gt  = sample > val_q;
	assign ins = gt ? (left.gt ? left.val : sample) : val_q;

	assign link.gt  = gt;
	assign link.val = val_q;
	assign link.ins = ins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (clear) begin
			val_q <= '0;
		end else if (shift_en) begin
			val_q <= ins;
		end
	end

endmodule

FILE: sv/mtaf_avg.sv
module mtaf_avg #(
	parameter int MEDIANS_PER_AVERAGE = 200
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtaf_pkg::median_t    median,
	output logic                 busy,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,
	output logic                 m_tuser
);
	import mtaf_pkg::*;

	localparam int SUM_W  = $clog2(MEDIANS_PER_AVERAGE * 4095 + 1);
	localparam int CNT_W  = $clog2(MEDIANS_PER_AVERAGE + 1);
	localparam int RCP_SH = SUM_W + $clog2(MEDIANS_PER_AVERAGE);
	localparam int RCP_W  = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH)
		+ 64'(MEDIANS_PER_AVERAGE - 1)) / 64'(MEDIANS_PER_AVERAGE));

	avg_state_t state_q, state_d;

	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    rem_q;
	logic [PROD_W-1:0]   prod;
	logic [AVG_W-1:0]    quot_next;
	logic [SAMPLE_W-1:0] med_hold_q;
	logic [AVG_W-1:0]    avg_q;
	logic                last_med;
	logic                div_done;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_med_q;
	logic [AVG_W-1:0]    out_avg_q;
	logic                out_fresh_q;

	assign sum_next  = sum_q + SUM_W'(median.value);
	assign last_med  = cnt_q == CNT_W'(MEDIANS_PER_AVERAGE - 1);
	assign busy      = state_q == AVG_DIV;

	// sum times a scaled reciprocal of MEDIANS_PER_AVERAGE, exact over the sum's range
	assign prod      = PROD_W'(rem_q) * PROD_W'(RCP);
	assign quot_next = prod[RCP_SH +: AVG_W];

	always_comb begin
		state_d  = state_q;
		div_done = 1'b0;
		case (state_q)
			AVG_IDLE: begin
				if (median.req && last_med) begin
					state_d = AVG_DIV;
				end
			end
			AVG_DIV: begin
				div_done = 1'b1;
				state_d  = AVG_IDLE;
			end
			default: state_d = AVG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AVG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			avg_q <= '0;
		end else if (median.req && state_q == AVG_IDLE) begin
			if (last_med) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (div_done) begin
			avg_q <= quot_next;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == AVG_IDLE) begin
			rem_q      <= sum_next;
			med_hold_q <= median.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((median.req && !last_med && state_q == AVG_IDLE) || div_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			out_med_q   <= med_hold_q;
			out_avg_q   <= quot_next;
			out_fresh_q <= 1'b1;
		end else if (median.req && !last_med && state_q == AVG_IDLE) begin
			out_med_q   <= median.value;
			out_avg_q   <= avg_q;
			out_fresh_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_avg_q, out_med_q};
	assign m_tuser  = out_fresh_q;

endmodule

FILE: sv/median_then_average_filter_core.sv
// Median-then-average filter for 12-bit converter samples.
// s_t* carries one sample per item (s_tdata[11:0]). Samples are sorted into a row
// of GROUP_SIZE compare-and-shift cells, one sample per cycle while s_tready is
// high. After every GROUP_SIZE samples the middle entry leaves on m_t* as the
// median and the row is cleared for the next group; no item is produced for
// other samples. m_tdata holds median [11:0] and the held average [23:12];
// m_tuser is high when the average was just recomputed (every MEDIANS_PER_AVERAGE
// medians). Throughput is one sample per cycle while s_tready is high. A plain
// median result is registered at the edge that takes the group's last sample.
// A result with a fresh average first passes the AVG_DIV state for the division
// by MEDIANS_PER_AVERAGE (a reciprocal multiply) and is registered as that
// state ends; s_tready is low for the whole of the AVG_DIV state.
// If m_tready is held low, samples that do not complete a group are still
// taken; the group's last sample waits until the output register is free.
// Reset clears the cells, the counts, the running sum and the average;
// samples are taken from the first edge after reset is released.
module median_then_average_filter_core #(
	parameter int GROUP_SIZE          = 16,
	parameter int MEDIANS_PER_AVERAGE = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // sample [11:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // median [11:0], average [23:12]
	output logic        m_tuser   // average_valid [0]
);
	import mtaf_pkg::*;

	localparam int GCNT_W = $clog2(GROUP_SIZE);
	localparam int MID    = GROUP_SIZE / 2;

	cell_link_t          links [GROUP_SIZE];
	logic [SAMPLE_W-1:0] sample;
	logic [GCNT_W-1:0]   gcnt_q;
	logic                accept;
	logic                last_smp;
	logic                clear;
	logic                busy;
	median_t             median;

	assign sample   = s_tdata[SAMPLE_W-1:0];
	assign last_smp = gcnt_q == GCNT_W'(GROUP_SIZE - 1);
	assign s_tready = !busy && (!last_smp || !m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign clear    = accept && last_smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcnt_q <= '0;
		end else if (clear) begin
			gcnt_q <= '0;
		end else if (accept) begin
			gcnt_q <= gcnt_q + 1'b1;
		end
	end

	for (genvar i = 0; i < GROUP_SIZE; i++) begin : g_cell
		cell_link_t left;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_rest
			assign left = links[i-1];
		end
		mtaf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.clear    (clear),
			.sample   (sample),
			.left     (left),
			.link     (links[i])
		);
	end

	assign median.req   = clear;
	assign median.value = links[MID].ins;

	mtaf_avg #(
		.MEDIANS_PER_AVERAGE (MEDIANS_PER_AVERAGE)
	) u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.median   (median),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: sv/mtaf_checker.sv
module mtaf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);
	logic [11:0] avg_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_seen_q <= '0;
		end else if (m_tvalid && m_tready && m_tuser) begin
			avg_seen_q <= m_tdata[23:12];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_avg_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[23:12] == avg_seen_q)
		else $error("held average differs from last fresh average");

	a_median_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && !m_tuser |-> $past(s_tvalid && s_tready))
		else $error("median item without a sample taken");

	a_avg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && m_tuser |-> $past(!s_tready))
		else $error("input taken while average was being divided");

endmodule

bind median_then_average_filter_core mtaf_checker u_mtaf_checker (.*);

FILE: dv/median_then_average_filter_core_tb.sv
`timescale 1ns / 100ps

module median_then_average_filter_core_tb;

	import mtaf_pkg::*;

	localparam int GROUP_SIZE          = 16;
	localparam int MEDIANS_PER_AVERAGE = 200;
	localparam int MIN_SAMPLES         = 1450;
	localparam int HOLD_OFF_CYCLES     = 400;
	localparam int TAIL_CYCLES         = 30;
	localparam int CYCLE_LIMIT         = 400000;

	typedef struct packed {
		logic [SAMPLE_W-1:0] median;
		logic [SAMPLE_W-1:0] average;
		logic                fresh;
	} filter_result_t;

	class median_scoreboard;
		logic [SAMPLE_W-1:0] ranks[GROUP_SIZE];
		int                  group_fill;
		int                  medians_in_sum;
		int                  median_total;
		logic [SAMPLE_W-1:0] held_average;
		filter_result_t      expected_q[$];
		int                  samples_noted;
		int                  fresh_predicted;
		int                  results_checked;
		int                  fresh_checked;
		int                  errors;

		function new();
			foreach (ranks[i])
				ranks[i] = '0;
			group_fill      = 0;
			medians_in_sum  = 0;
			median_total    = 0;
			held_average    = '0;
			samples_noted   = 0;
			fresh_predicted = 0;
			results_checked = 0;
			fresh_checked   = 0;
			errors          = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// Insert before the first strictly smaller entry; equal values stay ahead.
		function void note_sample(logic [SAMPLE_W-1:0] value);
			int             slot;
			int             k;
			filter_result_t r;
			samples_noted++;
			slot = 0;
			while (slot < GROUP_SIZE && ranks[slot] >= value)
				slot++;
			if (slot < GROUP_SIZE) begin
				for (k = GROUP_SIZE - 1; k > slot; k--)
					ranks[k] = ranks[k-1];
				ranks[slot] = value;
			end
			group_fill++;
			if (group_fill < GROUP_SIZE)
				return;
			r.median = ranks[GROUP_SIZE/2];
			r.fresh  = 1'b0;
			foreach (ranks[i])
				ranks[i] = '0;
			group_fill = 0;
			median_total += r.median;
			medians_in_sum++;
			if (medians_in_sum >= MEDIANS_PER_AVERAGE) begin
				held_average   = SAMPLE_W'(median_total / MEDIANS_PER_AVERAGE);
				median_total   = 0;
				medians_in_sum = 0;
				r.fresh        = 1'b1;
				fresh_predicted++;
			end
			r.average = held_average;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [23:0] data, logic user);
			filter_result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result item: median %0d, average %0d, average_valid %0b",
					data[11:0], data[23:12], user);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (user)
				fresh_checked++;
			if (data[11:0] !== want.median) begin
				$error("median: expected %0d, got %0d", want.median, data[11:0]);
				errors++;
			end
			if (data[23:12] !== want.average) begin
				$error("average: expected %0d, got %0d", want.average, data[23:12]);
				errors++;
			end
			if (user !== want.fresh) begin
				$error("average_valid: expected %0b, got %0b", want.fresh, user);
				errors++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;

	median_scoreboard sb;
	int send_idle_pct = 11;
	int recv_idle_pct = 51;
	int hold_left     = 0;
	int cycles        = 0;

	// extremes, ties, alternating bit patterns and zeros into an all-zero store
	logic [SAMPLE_W-1:0] directed_samples[25] = '{
		12'hFFF, 12'h000, 12'hFFF, 12'h001, 12'h800, 12'h800, 12'h800, 12'h000,
		12'hFFF, 12'h7FF, 12'hAAA, 12'h555, 12'h001, 12'hFFE, 12'h000, 12'h800,
		12'h000, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h800, 12'h7FF,
		12'h000
	};

	median_then_average_filter_core #(
		.GROUP_SIZE          (GROUP_SIZE),
		.MEDIANS_PER_AVERAGE (MEDIANS_PER_AVERAGE)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return $urandom_range(1) ? 12'hFFF : 12'h000;
			1, 2:    return SAMPLE_W'($urandom_range(2056, 2047));
			3:       return SAMPLE_W'($urandom_range(15));
			default: return SAMPLE_W'($urandom_range(4095));
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, value};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(value);
	endtask

	task automatic wait_for_medians();
		while (sb.outstanding() != 0) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_samples[i])
			send_sample(directed_samples[i]);

		n = 0;
		while (sb.samples_noted < MIN_SAMPLES) begin
			if (n == 475) begin
				send_idle_pct = 51;
				recv_idle_pct = 11;
			end else if (n == 950) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n == 300 || n == 1150)
				hold_left = HOLD_OFF_CYCLES;
			if (n == 700 || n == 1300)
				wait_for_medians();
			send_sample(pick_sample());
			n++;
		end

		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d samples sent, %0d medians checked, %0d of them with a fresh average",
			sb.samples_noted, sb.results_checked, sb.fresh_checked);
		$display("stalls on both sides, a long output hold-off and drained pauses included");
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
